// ----- src/afskcd_pkg.sv -----
// Shared types, widths and correlation coefficients for the AFSK demodulator.
// No dependencies; every other file imports this package.
package afskcd_pkg;

  localparam int Taps    = 8;
  localparam int SampleW = 8;
  localparam int TapW    = SampleW + 1;
  localparam int CoefW   = 8;
  localparam int ProdW   = TapW + CoefW;
  localparam int AccW    = 18;
  localparam int SumW    = SampleW + $clog2(Taps);
  localparam int MagW    = AccW - 8 + 1;
  localparam int ScoreW  = 11;
  localparam int CmpW    = MagW + 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 2'd0,
    CfgMidscale  = 2'd1
  } cfg_idx_e;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [TapW-1:0]    tap_t;
  typedef tap_t        [Taps-1:0]    tap_vec_t;
  typedef logic signed [CoefW-1:0]   coef_t;
  typedef logic signed [AccW-1:0]    acc_t;

  typedef struct packed {
    acc_t low_i;
    acc_t low_q;
    acc_t high_i;
    acc_t high_q;
  } corr_t;

  localparam coef_t CoefA [Taps] = '{8'sd64, 8'sd45, 8'sd0, -8'sd45,
                                     -8'sd64, -8'sd45, 8'sd0, 8'sd45};
  localparam coef_t CoefB [Taps] = '{8'sd0, 8'sd45, 8'sd64, 8'sd45,
                                     8'sd0, -8'sd45, -8'sd64, -8'sd45};
  localparam coef_t CoefC [Taps] = '{8'sd64, 8'sd8, -8'sd62, -8'sd24,
                                     8'sd55, 8'sd39, -8'sd45, -8'sd51};
  localparam coef_t CoefD [Taps] = '{8'sd0, 8'sd63, 8'sd17, -8'sd59,
                                     -8'sd32, 8'sd51, 8'sd45, -8'sd39};

  function automatic acc_t corr_dot(input tap_vec_t t, input coef_t c [Taps]);
    acc_t                    acc;
    logic signed [ProdW-1:0] prod;
    acc = '0;
    for (int k = 0; k < Taps; k++) begin
      prod = t[k] * c[k];
      acc  = acc + AccW'(prod);
    end
    return acc;
  endfunction

endpackage

// ----- src/afskcd_if.sv -----
// Valid/ready channel interfaces for samples in and demodulated results out.
// Depends on afskcd_pkg for field widths.
interface afskcd_in_if;
  import afskcd_pkg::*;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface afskcd_out_if;
  import afskcd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     data_bit;
  logic signed [ScoreW-1:0] score;

  modport source (output valid, output data_bit, output score, input ready);
  modport sink   (input valid, input data_bit, input score, output ready);
endinterface

// ----- src/afskcd_window.sv -----
// Sample window: offset removal, 8-deep sample line and mean-removed taps.
// Depends on afskcd_pkg.
module afskcd_window (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [afskcd_pkg::SampleW-1:0]  adc_sample_i,
  input  logic [afskcd_pkg::CfgW-1:0]     midscale_i,
  output logic                            taps_valid_o,
  input  logic                            taps_ready_i,
  output afskcd_pkg::tap_vec_t            taps_o
);
  import afskcd_pkg::*;

  sample_t              win_q [Taps];
  logic                 win_valid_q;
  logic                 taps_valid_q;
  tap_vec_t             taps_q;
  sample_t              s;
  logic                 accept;
  logic                 win_ready;
  logic                 win_move;
  logic signed [SumW-1:0] sum;
  sample_t              avg;

  assign s         = sample_t'(adc_sample_i - midscale_i);
  assign win_ready = !taps_valid_q || taps_ready_i;
  assign in_ready_o = !win_valid_q || win_ready;
  assign accept    = in_valid_i && in_ready_o;
  assign win_move  = win_valid_q && win_ready;

  // The window is kept oldest first, so index 0 is the oldest sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Taps; k++) win_q[k] <= '0;
      win_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        for (int k = 0; k < Taps - 1; k++) win_q[k] <= win_q[k+1];
        win_q[Taps-1] <= s;
      end
      if (accept) begin
        win_valid_q <= 1'b1;
      end else if (win_move) begin
        win_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < Taps; k++) sum = sum + SumW'(win_q[k]);
  end

  assign avg = sum[SumW-1:SumW-SampleW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_valid_q <= 1'b0;
    end else if (win_ready) begin
      taps_valid_q <= win_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_move) begin
      for (int k = 0; k < Taps; k++) taps_q[k] <= TapW'(win_q[k]) - TapW'(avg);
    end
  end

  assign taps_valid_o = taps_valid_q;
  assign taps_o       = taps_q;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> win_valid_q)
    else $error("accepted item did not reach the window stage");

  a_newest_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (win_q[Taps-1] == $past(s)))
    else $error("newest window entry does not match the accepted item");

endmodule

// ----- src/afskcd_correlator.sv -----
// Quadrature correlation of the eight taps against the 1200 Hz and 2200 Hz
// references. Depends on afskcd_pkg.
module afskcd_correlator (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  taps_valid_i,
  output logic                  taps_ready_o,
  input  afskcd_pkg::tap_vec_t  taps_i,
  output logic                  corr_valid_o,
  input  logic                  corr_ready_i,
  output afskcd_pkg::corr_t     corr_o
);
  import afskcd_pkg::*;

  logic  corr_valid_q;
  corr_t corr_q;
  corr_t corr_d;
  logic  load;

  assign taps_ready_o = !corr_valid_q || corr_ready_i;
  assign load         = taps_valid_i && taps_ready_o;

  always_comb begin
    corr_d.low_i  = corr_dot(taps_i, CoefA);
    corr_d.low_q  = corr_dot(taps_i, CoefB);
    corr_d.high_i = corr_dot(taps_i, CoefC);
    corr_d.high_q = corr_dot(taps_i, CoefD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_valid_q <= 1'b0;
    end else if (taps_ready_o) begin
      corr_valid_q <= taps_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      corr_q <= corr_d;
    end
  end

  assign corr_valid_o = corr_valid_q;
  assign corr_o       = corr_q;

endmodule

// ----- src/afskcd_decision.sv -----
// Magnitudes, tone score and hysteresis decision, held in the result register.
// Depends on afskcd_pkg.
module afskcd_decision (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               corr_valid_i,
  output logic                               corr_ready_o,
  input  afskcd_pkg::corr_t                  corr_i,
  input  logic [afskcd_pkg::CfgW-1:0]        threshold_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               data_bit_o,
  output logic signed [afskcd_pkg::ScoreW-1:0] score_o
);
  import afskcd_pkg::*;

  logic                     out_valid_q;
  logic                     held_bit_q;
  logic                     held_bit_d;
  logic signed [ScoreW-1:0] score_q;
  logic [MagW-1:0]          mag_a, mag_b, mag_c, mag_d;
  logic signed [CmpW-1:0]   score_full;
  logic signed [CmpW-1:0]   thr_ext;
  logic                     load;

  function automatic logic [MagW-1:0] mag_of(input acc_t x);
    logic signed [MagW-1:0] v;
    v = MagW'($signed(x[AccW-1:8]));
    return v[MagW-1] ? MagW'(-v) : MagW'(v);
  endfunction

  assign mag_a = mag_of(corr_i.low_i);
  assign mag_b = mag_of(corr_i.low_q);
  assign mag_c = mag_of(corr_i.high_i);
  assign mag_d = mag_of(corr_i.high_q);

  assign score_full = CmpW'(mag_c) + CmpW'(mag_d) - CmpW'(mag_a) - CmpW'(mag_b);
  assign thr_ext    = CmpW'(threshold_i);

  always_comb begin
    held_bit_d = held_bit_q;
    if (score_full > thr_ext) begin
      held_bit_d = 1'b1;
    end else if (score_full < -thr_ext) begin
      held_bit_d = 1'b0;
    end
  end

  assign corr_ready_o = !out_valid_q || out_ready_i;
  assign load         = corr_valid_i && corr_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_bit_q  <= 1'b0;
    end else begin
      if (corr_ready_o) begin
        out_valid_q <= corr_valid_i;
      end
      if (load) begin
        held_bit_q <= held_bit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      score_q <= score_full[ScoreW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_bit_o  = held_bit_q;
  assign score_o     = score_q;

  a_high_sets_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (score_full > thr_ext)) |=> held_bit_q)
    else $error("score above threshold did not set the data bit");

  a_low_clears_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (score_full < -thr_ext)) |=> !held_bit_q)
    else $error("score below negative threshold did not clear the data bit");

  a_bit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load |=> $stable(held_bit_q))
    else $error("data bit changed without a new item");

endmodule

// ----- src/afsk_correlation_demodulator_top.sv -----
// Top level of the Bell 202 AFSK correlation demodulator: configuration
// registers and the pipeline stages. Depends on afskcd_pkg, afskcd_if.
//
//   Channel   Direction  Payload
//   sample_i  in         adc_sample[7:0]
//   result_o  out        data_bit, score[10:0] signed
//   cfg_*     in         cfg_index_i 0 = threshold, 1 = midscale
//
// One item is accepted per cycle while no stall holds the sample window; its
// result reaches the result register after the tap and correlation registers.
// The stages are the sample window, the tap register, the correlation register
// and the result register, each with its own valid bit and ready path.
// A stalled result register back-pressures stage by stage, so empty stages
// keep accepting. Reset clears the window, the data bit and all valid bits.
module afsk_correlation_demodulator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  afskcd_in_if.sink                     sample_i,
  afskcd_out_if.source                  result_o,
  input  logic                          cfg_we_i,
  input  logic [afskcd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [afskcd_pkg::CfgW-1:0]   cfg_wdata_i
);
  import afskcd_pkg::*;

  logic [CfgW-1:0] threshold_q;
  logic [CfgW-1:0] midscale_q;
  logic            taps_valid;
  logic            taps_ready;
  tap_vec_t        taps;
  logic            corr_valid;
  logic            corr_ready;
  corr_t           corr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= CfgW'(4);
      midscale_q  <= CfgW'(127);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgThreshold: threshold_q <= cfg_wdata_i;
        CfgMidscale:  midscale_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  afskcd_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (sample_i.valid),
    .in_ready_o   (sample_i.ready),
    .adc_sample_i (sample_i.adc_sample),
    .midscale_i   (midscale_q),
    .taps_valid_o (taps_valid),
    .taps_ready_i (taps_ready),
    .taps_o       (taps)
  );

  afskcd_correlator u_correlator (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .taps_valid_i (taps_valid),
    .taps_ready_o (taps_ready),
    .taps_i       (taps),
    .corr_valid_o (corr_valid),
    .corr_ready_i (corr_ready),
    .corr_o       (corr)
  );

  afskcd_decision u_decision (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .corr_valid_i (corr_valid),
    .corr_ready_o (corr_ready),
    .corr_i       (corr),
    .threshold_i  (threshold_q),
    .out_valid_o  (result_o.valid),
    .out_ready_i  (result_o.ready),
    .data_bit_o   (result_o.data_bit),
    .score_o      (result_o.score)
  );

endmodule
